// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker file of the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, held off while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/bst_pkg.sv =====
// types, codes and constants of the semaphore table core
package bst_pkg;

    // field widths of the command and result beats
    localparam int CMD_W       = 2;
    localparam int SEM_IDX_W   = 4;
    localparam int THREAD_ID_W = 4;
    localparam int STATUS_W    = 2;

    // entries reachable through the index field, also the upper bound of the scan width
    localparam int IDX_SPAN = 2 ** SEM_IDX_W;

    // default sizes
    localparam int NUM_SEMS_DEF    = 16;
    localparam int NUM_THREADS_DEF = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_DOWN  = 2'd2,
        CMD_UP    = 2'd3
    } t_command;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_BLOCKED     = 2'd1,
        ST_NONE_FREE   = 2'd2,
        ST_HAS_WAITERS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic req_alloc;
        logic scan_hit;
        logic scan_last;
    } t_dp_stat;

endpackage

// ===== rtl/core/bst_datapath.sv =====
// datapath: command registers, semaphore state, allocation scan and result registers
module bst_datapath #(
    parameter int NUM_SEMS    = bst_pkg::NUM_SEMS_DEF,
    parameter int NUM_THREADS = bst_pkg::NUM_THREADS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [bst_pkg::CMD_W-1:0]        i_command,
    input  logic [bst_pkg::SEM_IDX_W-1:0]    i_sem_index,
    input  logic [bst_pkg::THREAD_ID_W-1:0]  i_thread_id,
    input  bst_pkg::t_dp_cmd                 i_cmd,
    output bst_pkg::t_dp_stat                o_stat,
    output logic [bst_pkg::STATUS_W-1:0]     o_status,
    output logic [bst_pkg::SEM_IDX_W-1:0]    o_granted_index,
    output logic                             o_woke_valid,
    output logic [bst_pkg::THREAD_ID_W-1:0]  o_woke_thread
);
    import bst_pkg::*;

    // entries seen per scan cycle; also the entries the index field can reach
    localparam int SCAN_W     = (NUM_SEMS < IDX_SPAN) ? NUM_SEMS : IDX_SPAN;
    localparam int NUM_CHUNKS = (NUM_SEMS + SCAN_W - 1) / SCAN_W;
    localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int PAD_SEMS   = NUM_CHUNKS * SCAN_W;
    localparam int SEM_W      = $clog2(NUM_SEMS);
    localparam int PICK_W     = $clog2(SCAN_W);
    localparam int ROWS       = SCAN_W;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int THR_W      = $clog2(NUM_THREADS);

    // captured command beat
    t_command                 r_command,   n_command;
    logic [SEM_IDX_W-1:0]     r_sem_index, n_sem_index;
    logic [THREAD_ID_W-1:0]   r_thread_id, n_thread_id;
    logic [CHUNK_W-1:0]       r_chunk,     n_chunk;

    // semaphore state
    logic [NUM_SEMS-1:0]      r_in_use,    n_in_use;
    logic [ROWS-1:0]          r_locked,    n_locked;
    logic [NUM_THREADS-1:0]   r_waiters [ROWS];
    logic [NUM_THREADS-1:0]   n_waiters [ROWS];

    // result beat
    t_status                  r_status,    n_status;
    logic [SEM_IDX_W-1:0]     r_granted,   n_granted;
    logic                     r_woke_valid, n_woke_valid;
    logic [THREAD_ID_W-1:0]   r_woke_thread, n_woke_thread;

    logic                     w_sem_ok;
    logic                     w_thr_ok;
    logic [ROW_W-1:0]         w_row;
    logic [NUM_THREADS-1:0]   w_wrow;
    logic                     w_wake_hit;
    logic [THR_W-1:0]         w_wake_pos;
    logic [PAD_SEMS-1:0]      w_in_use_pad;
    logic [SCAN_W-1:0]        w_chunk_used;
    logic                     w_hit;
    logic [PICK_W-1:0]        w_hit_pos;
    logic                     w_last;
    logic [SEM_W-1:0]         w_alloc_pos;

    // addressed entry and its waiter row
    assign w_sem_ok = int'(r_sem_index) < NUM_SEMS;
    assign w_thr_ok = int'(r_thread_id) < NUM_THREADS;
    assign w_row    = r_sem_index[ROW_W-1:0];
    assign w_wrow   = r_waiters[w_row];

    // lowest waiting thread of the addressed entry
    always_comb begin
        w_wake_hit = 1'b0;
        w_wake_pos = '0;
        for (int i = NUM_THREADS - 1; i >= 0; i--) begin
            if (w_wrow[i]) begin
                w_wake_hit = 1'b1;
                w_wake_pos = THR_W'(i);
            end
        end
    end

    // in-use vector padded to whole chunks, padding reads as taken
    always_comb begin
        w_in_use_pad                 = '1;
        w_in_use_pad[NUM_SEMS-1:0]   = r_in_use;
    end

    assign w_chunk_used = w_in_use_pad[int'(r_chunk) * SCAN_W +: SCAN_W];

    // lowest free entry of the current chunk
    always_comb begin
        w_hit     = 1'b0;
        w_hit_pos = '0;
        for (int j = SCAN_W - 1; j >= 0; j--) begin
            if (!w_chunk_used[j]) begin
                w_hit     = 1'b1;
                w_hit_pos = PICK_W'(j);
            end
        end
    end

    assign w_last      = int'(r_chunk) == (NUM_CHUNKS - 1);
    assign w_alloc_pos = SEM_W'(int'(r_chunk) * SCAN_W + int'(w_hit_pos));

    // next state of registers
    always_comb begin
        n_command     = r_command;
        n_sem_index   = r_sem_index;
        n_thread_id   = r_thread_id;
        n_chunk       = r_chunk;
        n_in_use      = r_in_use;
        n_locked      = r_locked;
        n_waiters     = r_waiters;
        n_status      = r_status;
        n_granted     = r_granted;
        n_woke_valid  = r_woke_valid;
        n_woke_thread = r_woke_thread;

        // capture a command beat
        if (i_cmd.load) begin
            n_command   = t_command'(i_command);
            n_sem_index = i_sem_index;
            n_thread_id = i_thread_id;
            n_chunk     = '0;
        end

        // free, down and up on the addressed entry
        if (i_cmd.exec) begin
            n_status      = ST_OK;
            n_granted     = '0;
            n_woke_valid  = 1'b0;
            n_woke_thread = '0;
            if (w_sem_ok) begin
                case (r_command)
                    CMD_FREE: begin
                        if (|w_wrow) begin
                            n_status = ST_HAS_WAITERS;
                        end else begin
                            n_in_use[SEM_W'(r_sem_index)] = 1'b0;
                            n_locked[w_row]               = 1'b0;
                        end
                    end
                    CMD_DOWN: begin
                        if (r_locked[w_row]) begin
                            if (w_thr_ok) begin
                                n_waiters[w_row][THR_W'(r_thread_id)] = 1'b1;
                            end
                            n_status = ST_BLOCKED;
                        end else begin
                            n_locked[w_row] = 1'b1;
                        end
                    end
                    CMD_UP: begin
                        if (r_locked[w_row]) begin
                            if (w_wake_hit) begin
                                n_waiters[w_row][w_wake_pos] = 1'b0;
                                n_woke_valid                 = 1'b1;
                                n_woke_thread                = THREAD_ID_W'(w_wake_pos);
                            end
                            n_locked[w_row] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        // allocation scan, one chunk per cycle
        if (i_cmd.scan) begin
            n_woke_valid  = 1'b0;
            n_woke_thread = '0;
            if (w_hit) begin
                n_in_use[w_alloc_pos] = 1'b1;
                n_status              = ST_OK;
                n_granted             = SEM_IDX_W'(w_hit_pos);
            end else if (w_last) begin
                n_status  = ST_NONE_FREE;
                n_granted = '0;
            end else begin
                n_chunk = r_chunk + 1'b1;
            end
        end
    end

    // semaphore state and scan position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
            r_locked <= '0;
            r_chunk  <= '0;
            for (int k = 0; k < ROWS; k++) begin
                r_waiters[k] <= '0;
            end
        end else begin
            r_in_use  <= n_in_use;
            r_locked  <= n_locked;
            r_chunk   <= n_chunk;
            r_waiters <= n_waiters;
        end
    end

    // command and result payload
    always_ff @(posedge i_clk) begin
        r_command     <= n_command;
        r_sem_index   <= n_sem_index;
        r_thread_id   <= n_thread_id;
        r_status      <= n_status;
        r_granted     <= n_granted;
        r_woke_valid  <= n_woke_valid;
        r_woke_thread <= n_woke_thread;
    end

    // status back to the controller
    assign o_stat.req_alloc = i_command == CMD_ALLOC;
    assign o_stat.scan_hit  = w_hit;
    assign o_stat.scan_last = w_last;

    assign o_status        = r_status;
    assign o_granted_index = r_granted;
    assign o_woke_valid    = r_woke_valid;
    assign o_woke_thread   = r_woke_thread;

endmodule

// ===== rtl/core/bst_ctrl.sv =====
// controller: sequences command capture, execution, allocation scan and result strobe
module bst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  bst_pkg::t_dp_stat  i_stat,
    output bst_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy,
    output logic               o_result_valid
);
    import bst_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE, S_DONE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.req_alloc ? S_SCAN : S_EXEC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_hit || i_stat.scan_last) begin
                    n_state = S_DONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // handshake outputs
    assign o_busy         = r_state inside {S_EXEC, S_SCAN};
    assign o_result_valid = r_state == S_DONE;

endmodule

// ===== rtl/core/binary_semaphore_table_core.sv =====
// Binary semaphore table with waiter bitmaps. A command beat is taken when start is high
// and busy is low; its result appears on the o_ result ports for one cycle with
// o_result_valid high and must be taken then, as it cannot be held. Free, down and up go
// from acceptance through S_EXEC to S_DONE, which raises the result strobe. Allocate goes
// through S_SCAN, which searches the in-use vector 16 entries a cycle (NUM_SEMS if fewer)
// until it finds a free entry or has searched the last group of entries, and then goes on
// to S_DONE. A new command can be given in the cycle the result strobe is high.
module binary_semaphore_table_core #(
    parameter int NUM_SEMS    = bst_pkg::NUM_SEMS_DEF,
    parameter int NUM_THREADS = bst_pkg::NUM_THREADS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [bst_pkg::CMD_W-1:0]        i_command,
    input  logic [bst_pkg::SEM_IDX_W-1:0]    i_sem_index,
    input  logic [bst_pkg::THREAD_ID_W-1:0]  i_thread_id,
    output logic                             o_result_valid,
    output logic [bst_pkg::STATUS_W-1:0]     o_status,
    output logic [bst_pkg::SEM_IDX_W-1:0]    o_granted_index,
    output logic                             o_woke_valid,
    output logic [bst_pkg::THREAD_ID_W-1:0]  o_woke_thread
);
    import bst_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencing
    bst_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_stat         (w_stat),
        .o_cmd          (w_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    // state and result datapath
    bst_datapath #(
        .NUM_SEMS    (NUM_SEMS),
        .NUM_THREADS (NUM_THREADS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_command       (i_command),
        .i_sem_index     (i_sem_index),
        .i_thread_id     (i_thread_id),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_woke_valid    (o_woke_valid),
        .o_woke_thread   (o_woke_thread)
    );

endmodule

// ===== rtl/core/bst_checker.sv =====
// port-level checks of the semaphore table core and their binding
`include "assert_macros.svh"

module bst_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_result_valid,
    input logic [bst_pkg::STATUS_W-1:0]     o_status,
    input logic [bst_pkg::SEM_IDX_W-1:0]    o_granted_index,
    input logic                             o_woke_valid,
    input logic [bst_pkg::THREAD_ID_W-1:0]  o_woke_thread
);
    import bst_pkg::*;

    // an accepted beat always puts the core to work
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // end of work always brings a result beat
    `ASSERT_IMPLIES(a_busy_end_result, i_clk, i_rst_n, $fell(busy), o_result_valid)

    // result strobe lasts a single cycle
    `ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_result_valid, !o_result_valid)

    // a woken thread only comes with a clean up result
    `ASSERT_IMPLIES(a_wake_clean, i_clk, i_rst_n, o_result_valid && o_woke_valid, o_status == ST_OK && o_granted_index == '0)

    // a granted entry only comes with a successful allocation
    `ASSERT_IMPLIES(a_grant_ok, i_clk, i_rst_n, o_result_valid && o_granted_index != '0, o_status == ST_OK && !o_woke_valid && o_woke_thread == '0)

endmodule

bind binary_semaphore_table_core bst_checker u_bst_checker (.*);
